// ===== rtl/gradient_line_rasterizer_macros.svh =====
// Assertion macros shared by the checker.
`ifndef GRADIENT_LINE_RASTERIZER_MACROS_SVH
`define GRADIENT_LINE_RASTERIZER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GLR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/glr_pkg.sv =====
package glr_pkg;
	localparam int MaxDimDefault = 2048;
	localparam int FracBits = 16;
	localparam int StatusW = 3;

	localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [StatusW-1:0] ST_OUT_OF_BOUNDS = 3'd1;
	localparam logic [StatusW-1:0] ST_ZERO_LENGTH = 3'd2;
	localparam logic [StatusW-1:0] ST_PIXEL = 3'd3;
	localparam logic [StatusW-1:0] ST_IDLE = 3'd4;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// Request to the shared divide / square root unit.
	typedef struct packed {
		logic go;
		logic sqrt_mode;
		logic [23:0] num;
		logic [11:0] den;
	} glr_ar_req_t;

	typedef struct packed {
		logic done;
		logic [23:0] quo;
	} glr_ar_rsp_t;
endpackage

// ===== rtl/glr_arith.sv =====
// Shared bit-serial unit: unsigned restoring division or integer square root,
// one result bit per cycle.
module glr_arith (
	input logic clk,
	input logic arst_n,
	input glr_pkg::glr_ar_req_t req,
	output glr_pkg::glr_ar_rsp_t rsp
);
	import glr_pkg::*;

	logic busy_q;
	logic mode_q;
	logic [4:0] cnt_q;
	logic [23:0] num_q;
	logic [11:0] den_q;
	logic [25:0] rem_q;
	logic [23:0] res_q;
	logic done_q;

	logic [25:0] rem_sh;
	logic [25:0] trial;
	logic ok;

	always_comb begin
		if (mode_q) begin
			// Two radicand bits per step; trial is 4*res+1.
			rem_sh = {rem_q[23:0], num_q[23:22]};
			trial = {res_q[23:0], 2'b01};
		end else begin
			rem_sh = {rem_q[24:0], num_q[23]};
			trial = {14'd0, den_q};
		end
		ok = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= req.sqrt_mode ? 5'd12 : 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			mode_q <= req.sqrt_mode;
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			num_q <= mode_q ? {num_q[21:0], 2'b00} : {num_q[22:0], 1'b0};
			rem_q <= ok ? rem_sh - trial : rem_sh;
			res_q <= {res_q[22:0], ok};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = res_q;
endmodule

// ===== rtl/gradient_line_rasterizer.sv =====
// Channel    Signals                                  Direction
// cmd        start, busy, action, start_*, end_*      in (busy out)
// result     strobe, status, pixel_*, last            out
// config     cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
// An advance, or an out-of-bounds start, strobes its result in the cycle after start.
// An accepted line start holds busy through a 12-step square root, then three 24-step
// divisions, all in the single shared bit-serial unit, and strobes its result as busy falls.
// A zero-length start strobes its result after the square root alone.
// Reset is asynchronous and active low; it restores the 640 by 480 canvas.
// Results cannot be stalled; busy is high while a start is being worked on.
module gradient_line_rasterizer #(
	parameter int MAX_DIM = glr_pkg::MaxDimDefault
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic action,
	input logic signed [11:0] start_x,
	input logic signed [11:0] start_y,
	input logic [31:0] start_color,
	input logic signed [11:0] end_x,
	input logic signed [11:0] end_y,
	input logic [31:0] end_color,
	output logic strobe,
	output logic [2:0] status,
	output logic [10:0] pixel_x,
	output logic [10:0] pixel_y,
	output logic [21:0] pixel_address,
	output logic [31:0] pixel_color,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [11:0] cfg_data
);
	import glr_pkg::*;

	localparam int AccW = FracBits + 10;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQRT = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;

	logic [2:0] state_q;
	logic [11:0] width_q, height_q;
	logic active_q;
	logic [10:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, dx_q, dy_q;
	logic [1:0] dir_q;
	logic signed [12:0] err_q;
	logic [31:0] base_q, color_q, end_col_q;
	logic signed [AccW-1:0] step_q [3];
	logic signed [AccW-1:0] acc_q [3];
	logic [11:0] dist_q;
	logic [1:0] ch_q;

	glr_ar_req_t req;
	glr_ar_rsp_t rsp;

	glr_arith u_arith (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	function automatic logic inb(input logic signed [11:0] c, input logic [11:0] lim);
		logic [12:0] l;
		begin
			l = (lim < 12'(MAX_DIM > 4095 ? 4095 : MAX_DIM)) ? {1'b0, lim}
				: 13'(MAX_DIM);
			inb = !c[11] && ({1'b0, c} < l);
		end
	endfunction

	logic signed [12:0] ddx, ddy;
	logic [11:0] adx, ady;
	logic in_ok;
	logic [23:0] sumsq;
	logic [7:0] ch_a, ch_b;
	logic neg_diff;

	always_comb begin
		ddx = 13'(end_x) - 13'(start_x);
		ddy = 13'(end_y) - 13'(start_y);
		adx = ddx[12] ? 12'(-ddx) : 12'(ddx);
		ady = ddy[12] ? 12'(-ddy) : 12'(ddy);
		in_ok = inb(start_x, width_q) && inb(end_x, width_q)
			&& inb(start_y, height_q) && inb(end_y, height_q);
		sumsq = 24'(adx * adx) + 24'(ady * ady);
		unique case (ch_q)
			2'd0: begin ch_a = base_q[31:24]; ch_b = end_col_q[31:24]; end
			2'd1: begin ch_a = base_q[23:16]; ch_b = end_col_q[23:16]; end
			default: begin ch_a = base_q[15:8]; ch_b = end_col_q[15:8]; end
		endcase
		neg_diff = ch_a < ch_b;
	end

	logic fire;
	assign fire = start && !busy;

	always_comb begin
		req = '0;
		if (fire && action == ACT_START && in_ok) begin
			req.go = 1'b1;
			req.sqrt_mode = 1'b1;
			req.num = sumsq;
		end else if (rsp.done && (state_q == S_SQRT || (state_q == S_DIV && ch_q != 2'd2))) begin
			req.go = (state_q == S_SQRT) ? (rsp.quo[11:0] != 12'd0) : 1'b1;
			req.sqrt_mode = 1'b0;
			req.den = (state_q == S_SQRT) ? rsp.quo[11:0] : dist_q;
			req.num = 24'(state_q == S_SQRT ? {1'b0, base_q[31:24] < end_col_q[31:24]
				? end_col_q[31:24] - base_q[31:24] : base_q[31:24] - end_col_q[31:24]}
				: 9'd0) << FracBits;
			if (state_q == S_DIV) begin
				unique case (ch_q)
					2'd0: req.num = 24'({1'b0, base_q[23:16] < end_col_q[23:16]
						? end_col_q[23:16] - base_q[23:16]
						: base_q[23:16] - end_col_q[23:16]}) << FracBits;
					default: req.num = 24'({1'b0, base_q[15:8] < end_col_q[15:8]
						? end_col_q[15:8] - base_q[15:8]
						: base_q[15:8] - end_col_q[15:8]}) << FracBits;
				endcase
			end
		end
	end

	// Next-pixel stepping.
	logic signed [13:0] e2;
	logic step_x, step_y, fin;
	logic [31:0] next_col;
	logic signed [AccW-1:0] acc_n [3];
	logic signed [AccW-1:0] tr [3];
	logic [31:0] cstep [3];
	always_comb begin
		e2 = {err_q, 1'b0};
		step_x = e2 > -$signed({3'd0, dy_q});
		step_y = e2 < $signed({3'd0, dx_q});
		fin = cur_x_q == tgt_x_q && cur_y_q == tgt_y_q;
		next_col = base_q;
		for (int k = 0; k < 3; k++) begin
			acc_n[k] = acc_q[k] - step_q[k];
			tr[k] = acc_n[k][AccW-1] ? -((-acc_n[k]) >>> FracBits) : acc_n[k] >>> FracBits;
			cstep[k] = 32'(tr[k]) << (24 - 8 * k);
			next_col = next_col + cstep[k];
		end
	end

	logic [23:0] addr_full;
	assign addr_full = 24'(cur_y_q * width_q) + 24'(cur_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 12'd640;
			height_q <= 12'd480;
			active_q <= 1'b0;
			strobe <= 1'b0;
			status <= '0;
			pixel_x <= '0;
			pixel_y <= '0;
			pixel_address <= '0;
			pixel_color <= '0;
			last <= 1'b0;
			ch_q <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fire && action == ACT_START) begin
						active_q <= 1'b0;
						if (!in_ok) begin
							strobe <= 1'b1;
							status <= ST_OUT_OF_BOUNDS;
							{pixel_x, pixel_y, pixel_address, pixel_color, last} <= '0;
						end else begin
							state_q <= S_SQRT;
						end
					end else if (fire) begin
						strobe <= 1'b1;
						if (!active_q) begin
							status <= ST_IDLE;
							{pixel_x, pixel_y, pixel_address, pixel_color, last} <= '0;
						end else begin
							status <= ST_PIXEL;
							pixel_x <= cur_x_q;
							pixel_y <= cur_y_q;
							pixel_address <= addr_full[21:0];
							pixel_color <= color_q;
							last <= fin;
							if (fin) active_q <= 1'b0;
						end
					end
				end
				S_SQRT: begin
					if (rsp.done) begin
						ch_q <= '0;
						if (rsp.quo[11:0] == 12'd0) begin
							state_q <= S_IDLE;
							strobe <= 1'b1;
							status <= ST_ZERO_LENGTH;
							{pixel_x, pixel_y, pixel_address, pixel_color, last} <= '0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (rsp.done) begin
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd2) begin
							state_q <= S_IDLE;
							active_q <= 1'b1;
							strobe <= 1'b1;
							status <= ST_ACCEPTED;
							{pixel_x, pixel_y, pixel_address, pixel_color, last} <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire && action == ACT_START && state_q == S_IDLE) begin
			cur_x_q <= start_x[10:0];
			cur_y_q <= start_y[10:0];
			tgt_x_q <= end_x[10:0];
			tgt_y_q <= end_y[10:0];
			dx_q <= adx[10:0];
			dy_q <= ady[10:0];
			dir_q <= {ddy > 0, ddx > 0};
			err_q <= $signed({1'b0, adx}) - $signed({1'b0, ady});
			base_q <= start_color;
			color_q <= start_color;
			end_col_q <= end_color;
		end else if (state_q == S_SQRT && rsp.done) begin
			dist_q <= rsp.quo[11:0];
		end else if (state_q == S_DIV && rsp.done) begin
			step_q[ch_q] <= neg_diff ? -$signed(AccW'(rsp.quo)) : $signed(AccW'(rsp.quo));
			acc_q[ch_q] <= '0;
		end else if (fire && action == ACT_ADVANCE && active_q && !fin) begin
			for (int k = 0; k < 3; k++) acc_q[k] <= acc_n[k];
			color_q <= next_col;
			if (step_x) begin
				err_q <= (step_y ? err_q + $signed({2'd0, dx_q}) : err_q) - $signed({2'd0, dy_q});
				cur_x_q <= dir_q[0] ? cur_x_q + 11'd1 : cur_x_q - 11'd1;
			end else if (step_y) begin
				err_q <= err_q + $signed({2'd0, dx_q});
			end
			if (step_y) cur_y_q <= dir_q[1] ? cur_y_q + 11'd1 : cur_y_q - 11'd1;
		end
	end

	assign busy = state_q != S_IDLE;
	assign cfg_ready = !busy;
endmodule

// ===== rtl/glr_checker.sv =====
`include "gradient_line_rasterizer_macros.svh"
module glr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic action,
	input logic strobe,
	input logic [2:0] status,
	input logic last
);
	import glr_pkg::*;
	`GLR_ASSERT_NEXT(a_adv_strobe, clk, arst_n, start && !busy && action == ACT_ADVANCE, strobe, "advance without result")
	`GLR_ASSERT_IMPL(a_last_pixel, clk, arst_n, strobe && last, status == ST_PIXEL, "last on non-pixel result")
	`GLR_ASSERT_IMPL(a_status_range, clk, arst_n, strobe, status <= ST_IDLE, "bad status")
	`GLR_ASSERT_NEXT(a_busy_ok, clk, arst_n, start && !busy && action == ACT_START && !strobe, !strobe || status == ST_OUT_OF_BOUNDS, "start result early")
endmodule

bind gradient_line_rasterizer glr_checker u_glr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
	.strobe(strobe), .status(status), .last(last)
);
